>>> rtl/sshit_pkg.sv
// Shared types and constants for the segment/sphere hit test unit.
// No dependencies; imported by sshit_mul and segment_sphere_hit_test_unit.
`default_nettype none

package sshit_pkg;

  localparam int unsigned LIMB_MAX = 32;

  typedef enum logic [1:0] {
    KIND_MISS     = 2'd0,
    KIND_ENDPOINT = 2'd1,
    KIND_CLOSEST  = 2'd2,
    KIND_DEGEN    = 2'd3
  } kind_e;

  typedef struct packed {
    logic near;
    logic degen;
    logic outside;
  } flags_t;

endpackage

`default_nettype wire

>>> rtl/sshit_mul.sv
// Unsigned W x W multiplier, three register stages: limb partial products,
// row sums, final sum. Depends on sshit_pkg for the limb width limit.
`default_nettype none

module sshit_mul #(
  parameter int unsigned W = 32
) (
  input  wire logic           clk_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic      [2*W-1:0] p_o
);
  import sshit_pkg::*;

  localparam int unsigned NL = (W + LIMB_MAX - 1) / LIMB_MAX;
  localparam int unsigned LW = (W + NL - 1) / NL;
  localparam int unsigned PW = NL * LW;

  logic [PW-1:0]     a_ext, b_ext;
  logic [2*LW-1:0]   pp_q [NL][NL];
  logic [2*PW-1:0]   row_d [NL];
  logic [2*PW-1:0]   row_q [NL];
  logic [2*PW-1:0]   p_d, p_q;

  assign a_ext = PW'(a_i);
  assign b_ext = PW'(b_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        pp_q[i][j] <= (2*LW)'(a_ext[i*LW +: LW]) * (2*LW)'(b_ext[j*LW +: LW]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_d[i] = row_d[i] + ((2*PW)'(pp_q[i][j]) << (j*LW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  always_comb begin
    p_d = '0;
    for (int i = 0; i < NL; i++) begin
      p_d = p_d + (row_q[i] << (i*LW));
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q[2*W-1:0];

endmodule

`default_nettype wire

>>> rtl/segment_sphere_hit_test_unit.sv
// Segment against sphere hit test, top level: difference stage, dot products,
// range checks and the final cross-multiplied compare. Uses sshit_pkg, sshit_mul.
//
// Usage:
//   A request is taken at every rising edge with start_i high; busy_o is
//   always low, so a new request may enter in every cycle.
//   Each request yields exactly one result on hit_o / hit_kind_o, marked by
//   valid_o for one cycle. valid_o is start_i delayed through a shift register
//   that keeps it aligned with the registered result.
//   Throughput is one request per cycle; latency is set by two cascaded
//   three-stage limb multipliers plus the difference, dot-sum and output
//   registers.
//   The receiver cannot hold results off; results leave in request order.
//   Reset (rst_ni low) drops every request in flight; no result appears for
//   them. There is no configuration and no state between requests.
//   hit_kind_o: miss, endpoint inside, closest point inside, or degenerate
//   segment (zero length, no endpoint inside).
`default_nettype none

module segment_sphere_hit_test_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [COORD_WIDTH-1:0]  center_x_i,
  input  wire logic [COORD_WIDTH-1:0]  center_y_i,
  input  wire logic [COORD_WIDTH-1:0]  center_z_i,
  input  wire logic [COORD_WIDTH-2:0]  sphere_radius_i,
  input  wire logic [COORD_WIDTH-1:0]  start_x_i,
  input  wire logic [COORD_WIDTH-1:0]  start_y_i,
  input  wire logic [COORD_WIDTH-1:0]  start_z_i,
  input  wire logic [COORD_WIDTH-1:0]  end_x_i,
  input  wire logic [COORD_WIDTH-1:0]  end_y_i,
  input  wire logic [COORD_WIDTH-1:0]  end_z_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic [1:0]                   hit_kind_o
);
  import sshit_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned SW  = 2 * CW + 2;
  localparam int unsigned LAT = 9;

  logic [LAT-1:0] v_q;

  logic [CW-1:0] c [3], s [3], e [3];
  logic [CW:0]   ws [3], we [3], dd [3];
  logic [CW-1:0] ws_mag_q [3], we_mag_q [3], d_mag_q [3];
  logic [2:0]    wd_neg_q, wd_neg1_q, wd_neg2_q, wd_neg3_q;
  logic [CW-2:0] rad_q;

  logic [2*CW-1:0] p_ww [3], p_ee [3], p_dd [3], p_wd [3], p_rr;

  logic [SW-1:0] ww_q, ee_q, den_q, r2_q;
  logic [SW:0]   num_q, num_d;

  flags_t        flg_d, flg1_q, flg2_q, flg3_q;
  logic [2*SW-1:0] big_wd, big_nn, big_rd;
  logic [2*SW:0]   rhs;
  logic          lt;
  kind_e         kind_d;
  logic          hit_q;
  kind_e         kind_q;

  assign busy_o = 1'b0;

  assign c[0] = center_x_i;
  assign c[1] = center_y_i;
  assign c[2] = center_z_i;
  assign s[0] = start_x_i;
  assign s[1] = start_y_i;
  assign s[2] = start_z_i;
  assign e[0] = end_x_i;
  assign e[1] = end_y_i;
  assign e[2] = end_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ws[k] = {c[k][CW-1], c[k]} - {s[k][CW-1], s[k]};
      we[k] = {c[k][CW-1], c[k]} - {e[k][CW-1], e[k]};
      dd[k] = {e[k][CW-1], e[k]} - {s[k][CW-1], s[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LAT-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ws_mag_q[k] <= ws[k][CW] ? CW'(-ws[k]) : ws[k][CW-1:0];
      we_mag_q[k] <= we[k][CW] ? CW'(-we[k]) : we[k][CW-1:0];
      d_mag_q[k]  <= dd[k][CW] ? CW'(-dd[k]) : dd[k][CW-1:0];
      wd_neg_q[k] <= ws[k][CW] ^ dd[k][CW];
    end
    rad_q     <= sphere_radius_i;
    wd_neg1_q <= wd_neg_q;
    wd_neg2_q <= wd_neg1_q;
    wd_neg3_q <= wd_neg2_q;
  end

  for (genvar k = 0; k < 3; k++) begin : g_dot
    sshit_mul #(.W(CW)) u_mul_ww (.clk_i, .a_i(ws_mag_q[k]), .b_i(ws_mag_q[k]), .p_o(p_ww[k]));
    sshit_mul #(.W(CW)) u_mul_ee (.clk_i, .a_i(we_mag_q[k]), .b_i(we_mag_q[k]), .p_o(p_ee[k]));
    sshit_mul #(.W(CW)) u_mul_dd (.clk_i, .a_i(d_mag_q[k]),  .b_i(d_mag_q[k]),  .p_o(p_dd[k]));
    sshit_mul #(.W(CW)) u_mul_wd (.clk_i, .a_i(ws_mag_q[k]), .b_i(d_mag_q[k]),  .p_o(p_wd[k]));
  end

  sshit_mul #(.W(CW)) u_mul_rr (
    .clk_i,
    .a_i (CW'(rad_q)),
    .b_i (CW'(rad_q)),
    .p_o (p_rr)
  );

  always_comb begin
    num_d = '0;
    for (int k = 0; k < 3; k++) begin
      num_d = num_d + (wd_neg3_q[k] ? (SW+1)'(-(SW+1)'(p_wd[k])) : (SW+1)'(p_wd[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    ww_q  <= SW'(p_ww[0]) + SW'(p_ww[1]) + SW'(p_ww[2]);
    ee_q  <= SW'(p_ee[0]) + SW'(p_ee[1]) + SW'(p_ee[2]);
    den_q <= SW'(p_dd[0]) + SW'(p_dd[1]) + SW'(p_dd[2]);
    num_q <= num_d;
    r2_q  <= SW'(p_rr);
  end

  always_comb begin
    flg_d.near    = (ww_q < r2_q) || (ee_q < r2_q);
    flg_d.degen   = (den_q == '0);
    flg_d.outside = num_q[SW] || (num_q[SW-1:0] > den_q);
  end

  sshit_mul #(.W(SW)) u_mul_wden (.clk_i, .a_i(ww_q), .b_i(den_q), .p_o(big_wd));
  sshit_mul #(.W(SW)) u_mul_nn (.clk_i, .a_i(num_q[SW-1:0]), .b_i(num_q[SW-1:0]), .p_o(big_nn));
  sshit_mul #(.W(SW)) u_mul_rden (.clk_i, .a_i(r2_q), .b_i(den_q), .p_o(big_rd));

  always_ff @(posedge clk_i) begin
    flg1_q <= flg_d;
    flg2_q <= flg1_q;
    flg3_q <= flg2_q;
  end

  assign rhs = (2*SW+1)'(big_rd) + (2*SW+1)'(big_nn);
  assign lt  = ({1'b0, big_wd} < rhs);

  always_comb begin
    priority if (flg3_q.near) begin
      kind_d = KIND_ENDPOINT;
    end else if (flg3_q.degen) begin
      kind_d = KIND_DEGEN;
    end else if (flg3_q.outside) begin
      kind_d = KIND_MISS;
    end else if (lt) begin
      kind_d = KIND_CLOSEST;
    end else begin
      kind_d = KIND_MISS;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    hit_q  <= (kind_d == KIND_ENDPOINT) || (kind_d == KIND_CLOSEST);
  end

  assign valid_o    = v_q[LAT-1];
  assign hit_o      = hit_q;
  assign hit_kind_o = kind_q;

  a_valid_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LAT))
    else $error("result without a request");

  a_hit_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> (hit_kind_o == KIND_ENDPOINT || hit_kind_o == KIND_CLOSEST))
    else $error("hit with a non-hit kind");

  a_miss_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !hit_o) |-> (hit_kind_o == KIND_MISS || hit_kind_o == KIND_DEGEN))
    else $error("miss with a hit kind");

endmodule

`default_nettype wire

>>> tb/tb_segment_sphere_hit_test_unit.sv
// Testbench for segment_sphere_hit_test_unit: drives hit-test requests from a
// directed table and then at random, and checks each result against an expected
// value from the table or a predictor. Depends on sshit_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_segment_sphere_hit_test_unit;
  import sshit_pkg::*;

  localparam int W = 32;
  localparam int N_RANDOM = 1750;

  typedef struct {
    logic signed [W-1:0] cx, cy, cz;
    logic [W-2:0]        rad;
    logic signed [W-1:0] sx, sy, sz, ex, ey, ez;
  } query_t;

  typedef struct {
    query_t q;
    logic   has_res;
    logic   hit;
    kind_e  kind;
  } row_t;

  typedef struct {
    logic  hit;
    kind_e kind;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, valid_o, hit_o;
  logic [1:0] hit_kind_o;
  query_t drv;

  res_t hit_queue[$];
  int   n_fail = 0;

  always #4 clk_i = ~clk_i;

  segment_sphere_hit_test_unit #(.COORD_WIDTH(W)) u_top (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .center_x_i(drv.cx), .center_y_i(drv.cy), .center_z_i(drv.cz),
    .sphere_radius_i(drv.rad),
    .start_x_i(drv.sx), .start_y_i(drv.sy), .start_z_i(drv.sz),
    .end_x_i(drv.ex), .end_y_i(drv.ey), .end_z_i(drv.ez),
    .valid_o, .hit_o, .hit_kind_o
  );

  function automatic res_t hit_predict(query_t q);
    logic signed [255:0] wsx, wsy, wsz, wex, wey, wez, dx, dy, dz;
    logic signed [255:0] r2, ds2, de2, num, den, lhs, rhs;
    res_t r;
    wsx = 256'(q.cx) - 256'(q.sx); wsy = 256'(q.cy) - 256'(q.sy);
    wsz = 256'(q.cz) - 256'(q.sz);
    wex = 256'(q.cx) - 256'(q.ex); wey = 256'(q.cy) - 256'(q.ey);
    wez = 256'(q.cz) - 256'(q.ez);
    dx = 256'(q.ex) - 256'(q.sx); dy = 256'(q.ey) - 256'(q.sy);
    dz = 256'(q.ez) - 256'(q.sz);
    r2 = $signed({225'd0, q.rad}) * $signed({225'd0, q.rad});
    ds2 = wsx * wsx + wsy * wsy + wsz * wsz;
    de2 = wex * wex + wey * wey + wez * wez;
    den = dx * dx + dy * dy + dz * dz;
    num = wsx * dx + wsy * dy + wsz * dz;
    r.hit = 1'b0;
    r.kind = KIND_MISS;
    if (ds2 < r2 || de2 < r2) begin
      r.hit = 1'b1;
      r.kind = KIND_ENDPOINT;
    end else if (den == 0) begin
      r.kind = KIND_DEGEN;
    end else if (!(num < 0 || num > den)) begin
      lhs = ds2 * den - num * num;
      rhs = r2 * den;
      if (lhs < rhs) begin
        r.hit = 1'b1;
        r.kind = KIND_CLOSEST;
      end
    end
    return r;
  endfunction

  function automatic query_t mk(int cx, int cy, int cz, int rad,
                                int sx, int sy, int sz, int ex, int ey, int ez);
    query_t q;
    q.cx = cx; q.cy = cy; q.cz = cz; q.rad = rad[W-2:0];
    q.sx = sx; q.sy = sy; q.sz = sz; q.ex = ex; q.ey = ey; q.ez = ez;
    return q;
  endfunction

  function automatic logic [W-1:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return W'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
      default: return W'($signed($urandom_range(0, 64)) - 32) <<< 16;
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 3);
    q.cx = rnd_coord(mode); q.cy = rnd_coord(mode); q.cz = rnd_coord(mode);
    q.sx = rnd_coord(mode); q.sy = rnd_coord(mode); q.sz = rnd_coord(mode);
    q.ex = rnd_coord(mode); q.ey = rnd_coord(mode); q.ez = rnd_coord(mode);
    case ($urandom_range(0, 5))
      0: q.rad = (W-1)'($urandom());
      1: q.rad = '0;
      default: q.rad = (mode == 0) ? (W-1)'($urandom())
                                   : (W-1)'($urandom_range(0, 24) << 16);
    endcase
    if ($urandom_range(0, 15) == 0) begin
      q.ex = q.sx; q.ey = q.sy; q.ez = q.sz;
    end
    return q;
  endfunction

  task automatic send_request(query_t q, res_t r, bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drv <= q;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    hit_queue.push_back(r);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (valid_o) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result hit=%b kind=%0d", $time, hit_o, hit_kind_o);
        n_fail++;
      end else begin
        e = hit_queue.pop_front();
        if (hit_o !== e.hit || hit_kind_o !== e.kind) begin
          $display("%0t: mismatch expected hit=%b kind=%0d actual hit=%b kind=%0d",
                   $time, e.hit, e.kind, hit_o, hit_kind_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    row_t tbl[$];
    row_t rw;
    res_t r;
    int  guard;
    int  mx, mn;
    mx = 32'h7fffffff; mn = 32'h80000000;
    drv = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // zero radius, degenerate segment
    rw.q = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rw.has_res = 1;
    rw.hit = 0; rw.kind = KIND_DEGEN; tbl.push_back(rw);
    rw.q = mk(0, 0, 0, 0, -65536, 0, 0, 65536, 0, 0);
    rw.hit = 0; rw.kind = KIND_MISS; tbl.push_back(rw);
    rw.q = mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0);
    rw.hit = 1; rw.kind = KIND_ENDPOINT; tbl.push_back(rw);
    rw.q = mk(0, 0, 0, 65536, 65536, 0, 0, 65536, 0, 0);
    rw.hit = 0; rw.kind = KIND_DEGEN; tbl.push_back(rw);
    rw.q = mk(0, 0, 0, 65536, -131072, 0, 0, 131072, 0, 0);
    rw.hit = 1; rw.kind = KIND_CLOSEST; tbl.push_back(rw);
    rw.q = mk(0, 0, 0, 65536, 131072, 0, 0, 262144, 0, 0);
    rw.hit = 0; rw.kind = KIND_MISS; tbl.push_back(rw);
    rw.has_res = 0;
    rw.q = mk(0, 0, 0, 65536, 65536, 0, 0, -65536, 0, 0); tbl.push_back(rw);
    rw.q = mk(0, 65536, 0, 65536, -131072, 65536, 0, 131072, 65536, 0); tbl.push_back(rw);
    rw.q = mk(0, 65535, 0, 65536, -131072, 0, 0, 131072, 0, 0); tbl.push_back(rw);
    rw.q = mk(mx, mx, mx, mx, mn, mn, mn, mx, mx, mx); tbl.push_back(rw);
    rw.q = mk(mn, mn, mn, mx, mx, mx, mx, mn, mn, mn); tbl.push_back(rw);
    rw.q = mk(mn, mn, mn, mx, mn, mn, mn, mn, mn, mn); tbl.push_back(rw);
    rw.q = mk(0, 0, 0, mx, mn, mn, mn, mx, mx, mx); tbl.push_back(rw);
    rw.q = mk(mx, mn, mx, 0, mx, mn, mx, mx, mn, mx); tbl.push_back(rw);
    rw.q = mk(-1, -1, -1, 1, 0, 0, 0, -2, -2, -2); tbl.push_back(rw);
    rw.q = mk(0, 0, 0, mx, mn, 0, 0, mn, 0, 0); tbl.push_back(rw);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (tbl[i]) begin
      r = hit_predict(tbl[i].q);
      if (tbl[i].has_res) begin
        r.hit = tbl[i].hit;
        r.kind = tbl[i].kind;
      end
      send_request(tbl[i].q, r, 1'b1);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      query_t q;
      q = rnd_query();
      send_request(q, hit_predict(q), i < N_RANDOM - 200);
    end
    start_i <= 1'b0;

    guard = 0;
    while (hit_queue.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && hit_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
